>>> hw/rtl/joint_stand_up_sequencer_core_assert.svh
// Assertion macros shared by the stand-up sequencer modules.
// Needs nothing else; each module that asserts includes this header.
`ifndef JOINT_STAND_UP_SEQUENCER_CORE_ASSERT_SVH
`define JOINT_STAND_UP_SEQUENCER_CORE_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define JSUS_ASSERT_SAME(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("stand-up sequencer assertion failed");

// The consequent must hold in the cycle after the antecedent.
`define JSUS_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("stand-up sequencer assertion failed");

`endif

>>> hw/rtl/jsus_pkg.sv
// Package of the stand-up sequencer: field widths, request, mode and register codes,
// beat structs and the command and status structs between controller and datapath.
// Depends on nothing.
`default_nettype none

package jsus_pkg;

	localparam int ANGLE_W    = 16;
	localparam int JIDX_W     = 4;
	localparam int STEP_W     = 24;
	localparam int FRAC_W     = STEP_W + 1;
	localparam int GAIN_W     = 16;
	localparam int HOLD_W     = 16;
	localparam int CFG_IDX_W  = 4;
	localparam int CFG_DATA_W = 24;

	// Rounding offset of one half in Q0.24.
	localparam logic [STEP_W-1:0] HALF_Q24 = 24'h80_0000;

	// Register reset values.
	localparam logic [STEP_W-1:0] STEP_RESET  = 24'd8389;
	localparam logic [GAIN_W-1:0] STIFF_RESET = 16'd2560;
	localparam logic [GAIN_W-1:0] DAMP_RESET  = 16'd64;
	localparam logic [HOLD_W-1:0] HOLD_RESET  = 16'd3000;

	// Register indexes of the configuration port.
	localparam logic [CFG_IDX_W-1:0] CFG_BLEND_STEP      = 4'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_BLEND_STIFFNESS = 4'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_BLEND_DAMPING   = 4'd2;
	localparam logic [CFG_IDX_W-1:0] CFG_WALK_HOLD_TICKS = 4'd3;

	typedef enum logic [1:0] {
		REQ_SAMPLE   = 2'd0,
		REQ_TICK     = 2'd1,
		REQ_ACTIVATE = 2'd2,
		REQ_LOAD     = 2'd3
	} req_t;

	typedef enum logic [1:0] {
		MODE_LIE   = 2'd0,
		MODE_STAND = 2'd1,
		MODE_WALK  = 2'd2
	} mode_t;

	typedef struct packed {
		req_t                      req_type;
		logic [JIDX_W-1:0]         joint_index;
		logic signed [ANGLE_W-1:0] joint_angle;
		logic                      start_event;
		logic                      estop_event;
	} in_item_t;

	typedef struct packed {
		logic [JIDX_W-1:0]         command_joint;
		logic signed [ANGLE_W-1:0] target_angle;
		logic [GAIN_W-1:0]         command_stiffness;
		logic [GAIN_W-1:0]         command_damping;
		logic                      stop_command;
		logic [1:0]                current_mode;
		logic                      last_command;
	} out_item_t;

	// Commands from the controller to the datapath.
	typedef struct packed {
		logic sample_wr;
		logic load_wr;
		logic activate;
		logic tick;
		logic rd;
		logic mul;
		logic emit;
	} dp_cmd_t;

	// Status from the datapath to the controller.
	typedef struct packed {
		logic run_req;
		logic last_joint;
		logic out_free;
	} dp_status_t;

endpackage

`default_nettype wire

>>> hw/rtl/jsus_ctrl.sv
// Controller of the stand-up sequencer: decodes input beats and steps through
// the per-joint command run. Depends on jsus_pkg and the assertion header.
`default_nettype none
`include "joint_stand_up_sequencer_core_assert.svh"

module jsus_ctrl
	import jsus_pkg::*;
(
	input  wire        clk,
	input  wire        arst_n,
	input  wire        in_valid,
	output logic       in_ready,
	input  req_t       in_req,
	input  dp_status_t sts,
	output dp_cmd_t    cmd
);

	typedef enum logic [3:0] {
		ST_IDLE = 4'b0001,
		ST_RD   = 4'b0010,
		ST_MUL  = 4'b0100,
		ST_EMIT = 4'b1000
	} state_t;

	state_t state_q;
	state_t state_d;

	// Input beats are taken only between runs.
	assign in_ready = (state_q == ST_IDLE);

	// Next state and datapath commands.
	always_comb begin
		cmd     = '0;
		state_d = state_q;
		case (state_q)
			ST_IDLE: begin
				if (in_valid) begin
					case (in_req)
						REQ_SAMPLE:   cmd.sample_wr = 1'b1;
						REQ_LOAD:     cmd.load_wr   = 1'b1;
						REQ_ACTIVATE: cmd.activate  = 1'b1;
						REQ_TICK: begin
							cmd.tick = 1'b1;
							if (sts.run_req) state_d = ST_RD;
						end
						default: ;
					endcase
				end
			end
			ST_RD: begin
				cmd.rd  = 1'b1;
				state_d = ST_MUL;
			end
			ST_MUL: begin
				cmd.mul = 1'b1;
				state_d = ST_EMIT;
			end
			ST_EMIT: begin
				if (sts.out_free) begin
					cmd.emit = 1'b1;
					state_d  = sts.last_joint ? ST_IDLE : ST_RD;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	// State register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	`JSUS_ASSERT_SAME(a_emit_needs_free_output, clk, arst_n, cmd.emit, sts.out_free)
	`JSUS_ASSERT_NEXT(a_read_then_multiply, clk, arst_n, state_q == ST_RD, state_q == ST_MUL)
	`JSUS_ASSERT_NEXT(a_last_emit_ends_run, clk, arst_n, cmd.emit && sts.last_joint,
		state_q == ST_IDLE)

endmodule

`default_nettype wire

>>> hw/rtl/jsus_datapath.sv
// Datapath of the stand-up sequencer: angle stores, mode and blend state, configuration
// registers, blend multiplier, output register. Uses jsus_pkg and the assertion header.
`default_nettype none
`include "joint_stand_up_sequencer_core_assert.svh"

module jsus_datapath
	import jsus_pkg::*;
#(
	parameter int JOINT_COUNT = 12
) (
	input  wire                   clk,
	input  wire                   arst_n,
	input  dp_cmd_t               cmd,
	output dp_status_t            sts,
	input  in_item_t              in_item,
	output logic                  out_valid,
	input  wire                   out_ready,
	output out_item_t             out_item,
	input  wire                   cfg_valid,
	input  wire [CFG_IDX_W-1:0]   cfg_index,
	input  wire [CFG_DATA_W-1:0]  cfg_data
);

	localparam int IW     = (JOINT_COUNT > 1) ? $clog2(JOINT_COUNT) : 1;
	localparam int DIFF_W = ANGLE_W + 1;
	localparam int PROD_W = DIFF_W + FRAC_W;
	localparam int SUM_W  = DIFF_W + 1;

	logic [ANGLE_W-1:0] meas_q  [JOINT_COUNT];
	logic [ANGLE_W-1:0] start_q [JOINT_COUNT];
	logic [ANGLE_W-1:0] stand_q [JOINT_COUNT];

	logic [STEP_W-1:0] step_q;
	logic [GAIN_W-1:0] stiff_q;
	logic [GAIN_W-1:0] damp_q;
	logic [HOLD_W-1:0] hold_q;

	logic [FRAC_W-1:0] frac_q;
	mode_t             mode_q;
	logic [HOLD_W-1:0] tick_q;
	logic              start_latch_q;
	logic              stop_latch_q;
	logic              act_q;
	logic              run_stop_q;
	logic [STEP_W-1:0] frac_run_q;
	logic [IW-1:0]     cnt_q;

	logic signed [ANGLE_W-1:0] a_s1;
	logic signed [DIFF_W-1:0]  diff_s1;
	logic signed [PROD_W-1:0]  prod_s2;

	logic              out_valid_q;
	out_item_t         out_q;

	logic [IW+JIDX_W-1:0] wr_ext;
	logic [IW-1:0]        wr_addr;
	logic                 wr_ok;
	logic                 start_n;
	logic                 stop_n;
	logic                 blend_go;
	logic                 restart;
	logic                 do_activate;
	logic [FRAC_W-1:0]    frac_sum;
	logic [HOLD_W-1:0]    tick_inc;
	logic                 last_joint;
	logic [IW+JIDX_W-1:0] cnt_ext;
	logic signed [PROD_W-1:0] round_sum;
	logic signed [SUM_W-1:0]  angle_sum;

	// Address decode for samples and standing-angle loads; out-of-range joints are dropped.
	assign wr_ext  = {{IW{1'b0}}, in_item.joint_index};
	assign wr_addr = wr_ext[IW-1:0];
	assign wr_ok   = (32'(in_item.joint_index) < JOINT_COUNT);

	// Tick decisions on the current state and this beat's events.
	assign start_n     = start_latch_q | in_item.start_event;
	assign stop_n      = stop_latch_q | in_item.estop_event;
	assign blend_go    = act_q && (mode_q == MODE_LIE) && !frac_q[FRAC_W-1];
	assign restart     = act_q && stop_n && start_n;
	assign do_activate = cmd.activate || (cmd.tick && restart);
	assign frac_sum    = frac_q + FRAC_W'(step_q);
	assign tick_inc    = (tick_q == '1) ? tick_q : tick_q + HOLD_W'(1);
	assign last_joint  = (cnt_q == IW'(JOINT_COUNT - 1));

	always_comb begin
		sts.run_req    = blend_go || (act_q && stop_n);
		sts.last_joint = last_joint;
		sts.out_free   = !out_valid_q || out_ready;
	end

	// Configuration registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			step_q  <= STEP_RESET;
			stiff_q <= STIFF_RESET;
			damp_q  <= DAMP_RESET;
			hold_q  <= HOLD_RESET;
		end else if (cfg_valid) begin
			case (cfg_index)
				CFG_BLEND_STEP:      step_q  <= cfg_data[STEP_W-1:0];
				CFG_BLEND_STIFFNESS: stiff_q <= cfg_data[GAIN_W-1:0];
				CFG_BLEND_DAMPING:   damp_q  <= cfg_data[GAIN_W-1:0];
				CFG_WALK_HOLD_TICKS: hold_q  <= cfg_data[HOLD_W-1:0];
				default: ;
			endcase
		end
	end

	// Measured angles, and the start angles captured from them on activation.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int j = 0; j < JOINT_COUNT; j++) begin
				meas_q[j]  <= '0;
				start_q[j] <= '0;
			end
		end else begin
			for (int j = 0; j < JOINT_COUNT; j++) begin
				if (cmd.sample_wr && wr_ok && (wr_addr == IW'(j))) begin
					meas_q[j] <= in_item.joint_angle;
				end
				if (do_activate) begin
					start_q[j] <= meas_q[j];
				end
			end
		end
	end

	// Standing angles hold whatever was last loaded.
	always_ff @(posedge clk) begin
		if (cmd.load_wr && wr_ok) begin
			stand_q[wr_addr] <= in_item.joint_angle;
		end
	end

	// Mode, blend fraction, tick count and the event latches.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			frac_q        <= '0;
			mode_q        <= MODE_LIE;
			tick_q        <= '0;
			start_latch_q <= 1'b0;
			stop_latch_q  <= 1'b0;
			act_q         <= 1'b0;
			run_stop_q    <= 1'b0;
			frac_run_q    <= '0;
		end else if (cmd.activate) begin
			frac_q <= '0;
			mode_q <= MODE_LIE;
			tick_q <= '0;
			act_q  <= 1'b1;
		end else if (cmd.tick && act_q) begin
			run_stop_q <= stop_n;
			frac_run_q <= frac_q[STEP_W-1:0];
			if (restart) begin
				// Restart after a stop: activation, then this tick is counted.
				frac_q        <= '0;
				mode_q        <= MODE_LIE;
				tick_q        <= HOLD_W'(1);
				start_latch_q <= 1'b0;
				stop_latch_q  <= 1'b0;
			end else begin
				start_latch_q <= start_n;
				stop_latch_q  <= stop_n;
				tick_q        <= tick_inc;
				case (mode_q)
					MODE_LIE: begin
						if (!frac_q[FRAC_W-1]) frac_q <= frac_sum;
						else mode_q <= MODE_STAND;
					end
					MODE_STAND: begin
						if ((tick_q > hold_q) && start_n) mode_q <= MODE_WALK;
					end
					default: ;
				endcase
			end
		end
	end

	// Joint counter of the command run.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
		end else if (cmd.tick) begin
			cnt_q <= '0;
		end else if (cmd.emit) begin
			cnt_q <= cnt_q + IW'(1);
		end
	end

	// Blend stages: read and difference, then the multiply.
	always_ff @(posedge clk) begin
		if (cmd.rd) begin
			a_s1    <= start_q[cnt_q];
			diff_s1 <= $signed({stand_q[cnt_q][ANGLE_W-1], stand_q[cnt_q]})
				- $signed({start_q[cnt_q][ANGLE_W-1], start_q[cnt_q]});
		end
		if (cmd.mul) begin
			prod_s2 <= diff_s1 * $signed({1'b0, frac_run_q});
		end
	end

	// Round to nearest, ties upward, and add the start angle.
	assign round_sum = prod_s2 + $signed(PROD_W'(HALF_Q24));
	assign angle_sum = $signed({{(SUM_W - ANGLE_W){a_s1[ANGLE_W-1]}}, a_s1})
		+ round_sum[PROD_W-1:STEP_W];
	assign cnt_ext   = {{JIDX_W{1'b0}}, cnt_q};

	// Output register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.emit) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.emit) begin
			out_q.command_joint     <= cnt_ext[JIDX_W-1:0];
			out_q.target_angle      <= run_stop_q ? '0 : angle_sum[ANGLE_W-1:0];
			out_q.command_stiffness <= run_stop_q ? '0 : stiff_q;
			out_q.command_damping   <= run_stop_q ? '0 : damp_q;
			out_q.stop_command      <= run_stop_q;
			out_q.current_mode      <= mode_q;
			out_q.last_command      <= last_joint;
		end
	end

	assign out_valid = out_valid_q;
	assign out_item  = out_q;

	`JSUS_ASSERT_SAME(a_stop_beat_is_zero, clk, arst_n, out_valid_q && out_q.stop_command,
		(out_q.target_angle == '0) && (out_q.command_stiffness == '0)
		&& (out_q.command_damping == '0))
	`JSUS_ASSERT_SAME(a_run_only_when_active, clk, arst_n, sts.run_req, act_q)
	`JSUS_ASSERT_NEXT(a_beat_held_until_taken, clk, arst_n, out_valid_q && !out_ready,
		out_valid_q && $stable(out_q))

endmodule

`default_nettype wire

>>> hw/rtl/joint_stand_up_sequencer_core.sv
// Stand-up sequencer core. Samples, loads, activations and silent ticks are taken while idle.
// A tick that emits commands steps each joint through read, multiply and emit states,
// with emit held while the output beat is not taken; the next beat waits for the last emit;
// the first result is registered after the read, multiply and emit states of the controller.
// Reset clears angle stores, mode, fraction, counters and latches at once; standing angles
// stay undefined until loaded. Depends on jsus_pkg, jsus_ctrl and jsus_datapath.
`default_nettype none

module joint_stand_up_sequencer_core
	import jsus_pkg::*;
#(
	parameter int JOINT_COUNT = 12
) (
	input  wire                   clk,
	input  wire                   arst_n,
	input  wire                   in_valid,
	output logic                  in_ready,
	input  in_item_t              in_item,
	output logic                  out_valid,
	input  wire                   out_ready,
	output out_item_t             out_item,
	input  wire                   cfg_valid,
	output logic                  cfg_ready,
	input  wire [CFG_IDX_W-1:0]   cfg_index,
	input  wire [CFG_DATA_W-1:0]  cfg_data
);

	dp_cmd_t    cmd;
	dp_status_t sts;

	// Register writes are taken in every cycle.
	assign cfg_ready = 1'b1;

	jsus_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.in_req   (in_item.req_type),
		.sts      (sts),
		.cmd      (cmd)
	);

	jsus_datapath #(
		.JOINT_COUNT (JOINT_COUNT)
	) u_datapath (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (cmd),
		.sts       (sts),
		.in_item   (in_item),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_item  (out_item),
		.cfg_valid (cfg_valid),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

endmodule

`default_nettype wire
